// ===== sv/rational_arithmetic_unit_core_defines.svh =====
// Assertion macros shared by the rational arithmetic unit RTL.
// Simulation builds get concurrent assertions; synthesis builds get empty bodies.
// No dependencies.
`ifndef RATIONAL_ARITHMETIC_UNIT_CORE_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define RAU_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define RAU_ASSERT_CORE(name, prop, msg) \
  `RAU_ASSERT(name, clk_i, rst_ni, prop, msg)

`else

`define RAU_ASSERT(name, clk, rstn, prop, msg)

`define RAU_ASSERT_CORE(name, prop, msg)

`endif

`endif

// ===== sv/rau_pkg.sv =====
`timescale 1ns / 1ps
// Types and constants of the rational arithmetic unit.
// Request and result structs, opcode and sequencer enums. No dependencies.
package rau_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } rau_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_COMBINE,
    ST_GCD_PAIR,
    ST_GCD_ODD,
    ST_GCD_SUB,
    ST_DIV,
    ST_FINISH
  } rau_state_e;

  typedef struct packed {
    rau_op_e            opcode;
    logic signed [15:0] a_num;
    logic signed [15:0] a_den;
    logic signed [15:0] b_num;
    logic signed [15:0] b_den;
  } rau_req_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic               res_nonneg;
    logic               res_is_integer;
    logic               res_error;
  } rau_res_t;

  localparam int unsigned FieldWidth = 16;

  localparam logic [63:0] DenMax    = 64'h0000_0000_4000_0000;
  localparam logic [63:0] NumPosMax = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] NumNegMax = 64'h0000_0000_8000_0000;

endpackage

// ===== sv/rational_arithmetic_unit_core.sv =====
`timescale 1ns / 1ps
// Rational arithmetic unit: add, subtract, multiply or divide two fractions and reduce.
// Depends on rau_pkg and rational_arithmetic_unit_core_defines.svh.
//
//   channel   ports                     handshake
//   request   start_i, busy_o, req_i    taken when start_i && !busy_o
//   result    valid_o, result_o         valid_o high for one cycle, always taken
//
// A request with a zero denominator or a divide by zero goes straight to the finish state.
// Otherwise the multiplier forms the products in turn, then a combine step, the binary gcd
// loop on SW-bit values (SW = 2*min(OPERAND_WIDTH,16)+1) and two passes of the shared
// one-bit-per-cycle divider, one for the numerator and one for the denominator.
// The result leaves through a register, so busy_o falls as valid_o rises.
// Reset clears the sequencer and the strobe; nothing needs clearing after it.
`include "rational_arithmetic_unit_core_defines.svh"

module rational_arithmetic_unit_core #(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  rau_pkg::rau_req_t req_i,
  output logic              busy_o,
  output logic              valid_o,
  output rau_pkg::rau_res_t result_o
);
  import rau_pkg::*;

  localparam int unsigned MW   = (OPERAND_WIDTH > FieldWidth) ? FieldWidth : OPERAND_WIDTH;
  localparam bit          SGN  = (OPERAND_WIDTH <= FieldWidth);
  localparam int unsigned PW   = 2 * MW;
  localparam int unsigned SW   = PW + 1;
  localparam int unsigned KW   = $clog2(SW + 1);
  localparam int unsigned IAN  = 0;
  localparam int unsigned IAD  = 1;
  localparam int unsigned IBN  = 2;
  localparam int unsigned IBD  = 3;

  rau_state_e state_q, state_d;
  rau_op_e    op_q, op_d;
  logic [MW-1:0] mag_q [4];
  logic [MW-1:0] mag_d [4];
  logic          sgn_q [4];
  logic          sgn_d [4];
  logic [1:0]    step_q, step_d;
  logic [PW-1:0] p_q [3];
  logic [PW-1:0] p_d [3];
  logic          ps_q [3];
  logic          ps_d [3];
  logic [SW-1:0] num_q, num_d, den_q, den_d;
  logic [SW-1:0] x_q, x_d, y_q, y_d, n_q, n_d, quo_q, quo_d, rem_q, rem_d;
  logic [KW-1:0] k_q, k_d, cnt_q, cnt_d;
  logic          neg_q, neg_d, pass_q, pass_d, fixed_q, fixed_d, err_q, err_d;
  logic          valid_q, valid_d;
  rau_res_t      res_q, res_d;

  logic [MW-1:0] raw_v [4];
  logic [MW-1:0] opd_mag [4];
  logic          opd_neg [4];
  logic          opd_zero [4];

  logic [MW-1:0] mx, my;
  logic          msgn;
  logic [PW-1:0] prod;

  logic          s1;
  logic [SW-1:0] sum_mag;
  logic          sum_neg;
  logic [SW:0]   r2;
  logic          ge;
  logic [63:0]   n64, d64;
  logic          ovf;

  assign raw_v[IAN] = req_i.a_num[MW-1:0];
  assign raw_v[IAD] = req_i.a_den[MW-1:0];
  assign raw_v[IBN] = req_i.b_num[MW-1:0];
  assign raw_v[IBD] = req_i.b_den[MW-1:0];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      opd_neg[i]  = SGN && raw_v[i][MW-1];
      opd_mag[i]  = opd_neg[i] ? (~raw_v[i] + 1'b1) : raw_v[i];
      opd_zero[i] = (raw_v[i] == '0);
    end
  end

  always_comb begin
    mx   = mag_q[IAD];
    my   = mag_q[IBD];
    msgn = sgn_q[IAD] ^ sgn_q[IBD];
    unique case (step_q)
      2'd0: begin
        mx = mag_q[IAN];
        if (op_q == OP_MUL) begin
          my   = mag_q[IBN];
          msgn = sgn_q[IAN] ^ sgn_q[IBN];
        end else begin
          my   = mag_q[IBD];
          msgn = sgn_q[IAN] ^ sgn_q[IBD];
        end
      end
      2'd1: begin
        mx = mag_q[IAD];
        case (op_q)
          OP_MUL: begin
            my   = mag_q[IBD];
            msgn = sgn_q[IAD] ^ sgn_q[IBD];
          end
          default: begin
            my   = mag_q[IBN];
            msgn = sgn_q[IAD] ^ sgn_q[IBN];
          end
        endcase
      end
      default: begin
        mx   = mag_q[IAD];
        my   = mag_q[IBD];
        msgn = sgn_q[IAD] ^ sgn_q[IBD];
      end
    endcase
  end

  assign prod = PW'(mx) * PW'(my);

  assign s1 = ps_q[1] ^ (op_q == OP_SUB);
  always_comb begin
    if (ps_q[0] == s1) begin
      sum_mag = SW'(p_q[0]) + SW'(p_q[1]);
      sum_neg = ps_q[0];
    end else if (p_q[0] >= p_q[1]) begin
      sum_mag = SW'(p_q[0] - p_q[1]);
      sum_neg = ps_q[0];
    end else begin
      sum_mag = SW'(p_q[1] - p_q[0]);
      sum_neg = s1;
    end
  end

  assign r2 = {rem_q, quo_q[SW-1]};
  assign ge = (r2 >= {1'b0, x_q});

  assign n64 = 64'(n_q);
  assign d64 = 64'(quo_q);
  assign ovf = (d64 > DenMax) || (n64 > (neg_q ? NumNegMax : NumPosMax));

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    mag_d   = mag_q;
    sgn_d   = sgn_q;
    step_d  = step_q;
    p_d     = p_q;
    ps_d    = ps_q;
    num_d   = num_q;
    den_d   = den_q;
    x_d     = x_q;
    y_d     = y_q;
    k_d     = k_q;
    n_d     = n_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    neg_d   = neg_q;
    pass_d  = pass_q;
    fixed_d = fixed_q;
    err_d   = err_q;
    valid_d = 1'b0;
    res_d   = res_q;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          op_d   = req_i.opcode;
          mag_d  = opd_mag;
          sgn_d  = opd_neg;
          step_d = 2'd0;
          if (opd_zero[IAD] || opd_zero[IBD] || (req_i.opcode == OP_DIV && opd_zero[IBN])) begin
            fixed_d = 1'b1;
            err_d   = 1'b1;
            state_d = ST_FINISH;
          end else begin
            fixed_d = 1'b0;
            err_d   = 1'b0;
            state_d = ST_MUL;
          end
        end
      end

      ST_MUL: begin
        p_d[step_q]  = prod;
        ps_d[step_q] = msgn;
        step_d       = step_q + 2'd1;
        if ((step_q == 2'd2) || (step_q == 2'd1 && (op_q == OP_MUL || op_q == OP_DIV))) begin
          state_d = ST_COMBINE;
        end
      end

      ST_COMBINE: begin
        case (op_q) inside
          OP_ADD, OP_SUB: begin
            num_d = sum_mag;
            den_d = SW'(p_q[2]);
            neg_d = sum_neg ^ ps_q[2];
          end
          default: begin
            num_d = SW'(p_q[0]);
            den_d = SW'(p_q[1]);
            neg_d = ps_q[0] ^ ps_q[1];
          end
        endcase
        x_d = num_d;
        y_d = den_d;
        k_d = '0;
        if (num_d == '0) begin
          fixed_d = 1'b1;
          state_d = ST_FINISH;
        end else begin
          state_d = ST_GCD_PAIR;
        end
      end

      ST_GCD_PAIR: begin
        if (!x_q[0] && !y_q[0]) begin
          x_d = x_q >> 1;
          y_d = y_q >> 1;
          k_d = k_q + 1'b1;
        end else begin
          state_d = ST_GCD_ODD;
        end
      end

      ST_GCD_ODD: begin
        if (!x_q[0]) begin
          x_d = x_q >> 1;
        end else begin
          state_d = ST_GCD_SUB;
        end
      end

      ST_GCD_SUB: begin
        if (y_q == '0) begin
          x_d     = x_q << k_q;
          quo_d   = num_q;
          rem_d   = '0;
          cnt_d   = '0;
          pass_d  = 1'b0;
          state_d = ST_DIV;
        end else if (!y_q[0]) begin
          y_d = y_q >> 1;
        end else if (x_q > y_q) begin
          x_d = y_q;
          y_d = x_q - y_q;
        end else begin
          y_d = y_q - x_q;
        end
      end

      ST_DIV: begin
        rem_d = ge ? SW'(r2 - {1'b0, x_q}) : SW'(r2);
        quo_d = {quo_q[SW-2:0], ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == KW'(SW - 1)) begin
          if (!pass_q) begin
            n_d    = quo_d;
            quo_d  = den_q;
            rem_d  = '0;
            cnt_d  = '0;
            pass_d = 1'b1;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end

      ST_FINISH: begin
        valid_d = 1'b1;
        state_d = ST_IDLE;
        if (fixed_q || ovf) begin
          res_d.res_num        = '0;
          res_d.res_den        = 31'd1;
          res_d.res_nonneg     = 1'b1;
          res_d.res_is_integer = 1'b1;
          res_d.res_error      = err_q || !fixed_q;
        end else begin
          res_d.res_num        = neg_q ? (32'd0 - n64[31:0]) : n64[31:0];
          res_d.res_den        = d64[30:0];
          res_d.res_nonneg     = !neg_q;
          res_d.res_is_integer = (d64 == 64'd1);
          res_d.res_error      = 1'b0;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    mag_q   <= mag_d;
    sgn_q   <= sgn_d;
    step_q  <= step_d;
    p_q     <= p_d;
    ps_q    <= ps_d;
    num_q   <= num_d;
    den_q   <= den_d;
    x_q     <= x_d;
    y_q     <= y_d;
    k_q     <= k_d;
    n_q     <= n_d;
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    cnt_q   <= cnt_d;
    neg_q   <= neg_d;
    pass_q  <= pass_d;
    fixed_q <= fixed_d;
    err_q   <= err_d;
    res_q   <= res_d;
  end

  assign busy_o   = (state_q != ST_IDLE);
  assign valid_o  = valid_q;
  assign result_o = res_q;

  `RAU_ASSERT_CORE(a_strobe_when_idle, valid_o |-> !busy_o, "result strobe while busy")
  `RAU_ASSERT_CORE(a_accept_goes_busy, (start_i && !busy_o) |=> busy_o, "request not taken")
  `RAU_ASSERT_CORE(a_single_strobe, valid_o |=> !valid_o, "result strobe held two cycles")
  `RAU_ASSERT_CORE(a_den_nonzero, valid_o |-> (result_o.res_den != '0), "zero denominator out")
  `RAU_ASSERT_CORE(a_sign_flag, valid_o |-> (result_o.res_nonneg == !result_o.res_num[31]),
    "sign flag disagrees with numerator")

endmodule
